[design/pfe_pkg.sv]
`default_nettype none

package pfe_pkg;

    localparam int WORD_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(WORD_W);

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FEW   = 3'd1;
    localparam logic [2:0] ST_LEFT  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

endpackage

`default_nettype wire

[design/pfe_stack_ram.sv]
`default_nettype none

module pfe_stack_ram (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [pfe_pkg::ADDR_W-1:0] waddr,
    input  wire logic [pfe_pkg::WORD_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [pfe_pkg::ADDR_W-1:0] raddr,
    output logic      [pfe_pkg::WORD_W-1:0] rdata
);

    logic [pfe_pkg::WORD_W-1:0] mem [pfe_pkg::STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/pfe_alu.sv]
`default_nettype none

module pfe_alu (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire pfe_pkg::alu_req_t          req,
    input  wire logic [pfe_pkg::WORD_W-1:0] opa,
    input  wire logic [pfe_pkg::WORD_W-1:0] opb,
    output logic      [pfe_pkg::WORD_W-1:0] result,
    output logic                            done
);

    typedef enum logic [3:0] {
        AL_IDLE = 4'b0001,
        AL_MUL  = 4'b0010,
        AL_DIV  = 4'b0100,
        AL_FIX  = 4'b1000
    } alu_state_t;

    alu_state_t                    state_reg;
    logic [pfe_pkg::WORD_W-1:0]    acc_reg;
    logic [pfe_pkg::WORD_W-1:0]    x_reg;
    logic [pfe_pkg::WORD_W-1:0]    y_reg;
    logic                          neg_reg;
    logic [pfe_pkg::STEP_W-1:0]    step_reg;
    logic [pfe_pkg::WORD_W-1:0]    res_reg;
    logic                          done_reg;

    logic [pfe_pkg::WORD_W-1:0]    mag_a;
    logic [pfe_pkg::WORD_W-1:0]    mag_b;
    logic [pfe_pkg::WORD_W-1:0]    mul_acc;
    logic [pfe_pkg::WORD_W:0]      rem_sh;
    logic [pfe_pkg::WORD_W+1:0]    rem_diff;

    assign mag_a = opa[pfe_pkg::WORD_W-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[pfe_pkg::WORD_W-1] ? (~opb + 1'b1) : opb;

    // Multiply: x holds the shifted multiplicand, y the remaining multiplier bits.
    assign mul_acc = acc_reg + (y_reg[0] ? x_reg : '0);

    // Divide: x shifts the dividend out as quotient bits shift in, y is the divisor.
    assign rem_sh   = {acc_reg, x_reg[pfe_pkg::WORD_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, y_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                AL_IDLE: begin
                    if (req.start) begin
                        case (req.op)
                            pfe_pkg::OP_ADD: begin
                                res_reg  <= opa + opb;
                                done_reg <= 1'b1;
                            end
                            pfe_pkg::OP_SUB: begin
                                res_reg  <= opa - opb;
                                done_reg <= 1'b1;
                            end
                            pfe_pkg::OP_MUL: begin
                                acc_reg   <= '0;
                                x_reg     <= opa;
                                y_reg     <= opb;
                                step_reg  <= pfe_pkg::STEP_W'(pfe_pkg::WORD_W - 1);
                                state_reg <= AL_MUL;
                            end
                            pfe_pkg::OP_DIV: begin
                                acc_reg   <= '0;
                                x_reg     <= mag_a;
                                y_reg     <= mag_b;
                                neg_reg   <= opa[pfe_pkg::WORD_W-1] ^ opb[pfe_pkg::WORD_W-1];
                                step_reg  <= pfe_pkg::STEP_W'(pfe_pkg::WORD_W - 1);
                                state_reg <= AL_DIV;
                            end
                            default: begin
                                state_reg <= AL_IDLE;
                            end
                        endcase
                    end
                end
                AL_MUL: begin
                    acc_reg  <= mul_acc;
                    x_reg    <= {x_reg[pfe_pkg::WORD_W-2:0], 1'b0};
                    y_reg    <= {1'b0, y_reg[pfe_pkg::WORD_W-1:1]};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        res_reg   <= mul_acc;
                        done_reg  <= 1'b1;
                        state_reg <= AL_IDLE;
                    end
                end
                AL_DIV: begin
                    if (!rem_diff[pfe_pkg::WORD_W+1]) begin
                        acc_reg <= rem_diff[pfe_pkg::WORD_W-1:0];
                        x_reg   <= {x_reg[pfe_pkg::WORD_W-2:0], 1'b1};
                    end else begin
                        acc_reg <= rem_sh[pfe_pkg::WORD_W-1:0];
                        x_reg   <= {x_reg[pfe_pkg::WORD_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= AL_FIX;
                    end
                end
                AL_FIX: begin
                    res_reg   <= neg_reg ? (~x_reg + 1'b1) : x_reg;
                    done_reg  <= 1'b1;
                    state_reg <= AL_IDLE;
                end
                default: begin
                    state_reg <= AL_IDLE;
                end
            endcase
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

[design/postfix_expression_evaluator_top.sv]
// Digits and ignored bytes are handled in the idle state; a space adds the flush step; operators
// add flush, operand check, load and the shared ALU, where multiply and divide run bit-serially.
// A last byte then goes to the tail state, which registers its result word onto m_tdata.
// One byte is in work at a time; the next result may wait in the output register.
// aresetn is synchronous, active low: it clears the sequencer, stack count, pending
// number and error; stack RAM contents are not cleared.
`default_nettype none

module postfix_expression_evaluator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] value
    output logic      [2:0]  m_tuser    // [2:0] status
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FLUSH = 6'b000010,
        S_OPCHK = 6'b000100,
        S_LOAD  = 6'b001000,
        S_ALU   = 6'b010000,
        S_TAIL  = 6'b100000
    } state_t;

    state_t                          state_reg;
    logic [pfe_pkg::COUNT_W-1:0]     count_reg;
    logic [pfe_pkg::WORD_W-1:0]      top_reg;
    logic [pfe_pkg::WORD_W-1:0]      pending_reg;
    logic                            dp_reg;
    logic [2:0]                      err_reg;
    logic                            last_reg;
    logic                            is_op_reg;
    pfe_pkg::op_t                    op_reg;
    logic                            m_valid_reg;
    logic [pfe_pkg::WORD_W-1:0]      m_value_reg;
    logic [2:0]                      m_status_reg;

    logic                            in_fire;
    logic                            is_digit;
    logic                            is_space;
    logic                            is_op;
    pfe_pkg::op_t                    op_dec;
    logic [7:0]                      dig;
    logic [pfe_pkg::WORD_W-1:0]      pending_next;
    state_t                          done_state;

    logic [pfe_pkg::COUNT_W-1:0]     cnt_m1;
    logic [pfe_pkg::COUNT_W-1:0]     cnt_m2;
    logic                            ram_we;
    logic                            ram_re;
    logic [pfe_pkg::WORD_W-1:0]      ram_rdata;

    pfe_pkg::alu_req_t               alu_req;
    logic [pfe_pkg::WORD_W-1:0]      alu_result;
    logic                            alu_done;

    logic                            stack_full;
    logic                            fl_full;
    logic [pfe_pkg::COUNT_W-1:0]     fl_count;
    logic [pfe_pkg::WORD_W-1:0]      fl_top;
    logic [2:0]                      tail_status;
    logic [pfe_pkg::WORD_W-1:0]      tail_value;
    logic                            tail_fire;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        is_digit = 1'b0;
        is_space = 1'b0;
        is_op    = 1'b0;
        op_dec   = pfe_pkg::OP_ADD;
        case (s_tdata) inside
            [pfe_pkg::CH_0:pfe_pkg::CH_9]: is_digit = 1'b1;
            pfe_pkg::CH_SPACE:             is_space = 1'b1;
            pfe_pkg::CH_PLUS: begin
                is_op  = 1'b1;
                op_dec = pfe_pkg::OP_ADD;
            end
            pfe_pkg::CH_MINUS: begin
                is_op  = 1'b1;
                op_dec = pfe_pkg::OP_SUB;
            end
            pfe_pkg::CH_STAR: begin
                is_op  = 1'b1;
                op_dec = pfe_pkg::OP_MUL;
            end
            pfe_pkg::CH_SLASH: begin
                is_op  = 1'b1;
                op_dec = pfe_pkg::OP_DIV;
            end
            default: is_op = 1'b0;
        endcase
    end

    assign dig          = s_tdata - pfe_pkg::CH_0;
    assign pending_next = (pending_reg << 3) + (pending_reg << 1) + pfe_pkg::WORD_W'(dig);
    assign done_state   = last_reg ? S_TAIL : S_IDLE;

    assign cnt_m1     = count_reg - 1'b1;
    assign cnt_m2     = count_reg - 2'd2;
    assign stack_full = (count_reg == pfe_pkg::COUNT_W'(pfe_pkg::STACK_DEPTH));

    // The top entry lives in top_reg; the RAM holds the entries below it.
    assign ram_we = (state_reg == S_FLUSH) && dp_reg && (err_reg == pfe_pkg::ST_OK)
                    && !stack_full && (count_reg != '0);
    assign ram_re = (state_reg == S_OPCHK);

    pfe_stack_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_m1[pfe_pkg::ADDR_W-1:0]),
        .wdata (top_reg),
        .re    (ram_re),
        .raddr (cnt_m2[pfe_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        alu_req.start = (state_reg == S_LOAD)
                        && !((op_reg == pfe_pkg::OP_DIV) && (top_reg == '0));
        alu_req.op    = op_reg;
    end

    pfe_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (ram_rdata),
        .opb     (top_reg),
        .result  (alu_result),
        .done    (alu_done)
    );

    // End of expression: a pending number is pushed, then the stack is judged.
    assign fl_full  = dp_reg && stack_full;
    assign fl_count = (dp_reg && !stack_full) ? (count_reg + 1'b1) : count_reg;
    assign fl_top   = dp_reg ? pending_reg : top_reg;

    always_comb begin
        tail_value = '0;
        if (err_reg != pfe_pkg::ST_OK) begin
            tail_status = err_reg;
        end else if (fl_full) begin
            tail_status = pfe_pkg::ST_FULL;
        end else if (fl_count == '0) begin
            tail_status = pfe_pkg::ST_EMPTY;
        end else if (fl_count == pfe_pkg::COUNT_W'(1)) begin
            tail_status = pfe_pkg::ST_OK;
            tail_value  = fl_top;
        end else begin
            tail_status = pfe_pkg::ST_LEFT;
        end
    end

    assign tail_fire = (state_reg == S_TAIL) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pending_reg <= '0;
            dp_reg      <= 1'b0;
            err_reg     <= pfe_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (tail_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        last_reg  <= s_tlast;
                        is_op_reg <= is_op;
                        op_reg    <= op_dec;
                        if (err_reg != pfe_pkg::ST_OK) begin
                            state_reg <= s_tlast ? S_TAIL : S_IDLE;
                        end else if (is_digit) begin
                            pending_reg <= pending_next;
                            dp_reg      <= 1'b1;
                            state_reg   <= s_tlast ? S_TAIL : S_IDLE;
                        end else if (is_space || is_op) begin
                            state_reg <= S_FLUSH;
                        end else begin
                            state_reg <= s_tlast ? S_TAIL : S_IDLE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (dp_reg) begin
                        if (stack_full) begin
                            err_reg <= pfe_pkg::ST_FULL;
                        end else begin
                            top_reg   <= pending_reg;
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    dp_reg      <= 1'b0;
                    pending_reg <= '0;
                    state_reg   <= is_op_reg ? S_OPCHK : done_state;
                end
                S_OPCHK: begin
                    if (err_reg != pfe_pkg::ST_OK) begin
                        state_reg <= done_state;
                    end else if (count_reg < pfe_pkg::COUNT_W'(2)) begin
                        err_reg   <= pfe_pkg::ST_FEW;
                        state_reg <= done_state;
                    end else begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if ((op_reg == pfe_pkg::OP_DIV) && (top_reg == '0)) begin
                        err_reg   <= pfe_pkg::ST_DIV0;
                        state_reg <= done_state;
                    end else begin
                        state_reg <= S_ALU;
                    end
                end
                S_ALU: begin
                    if (alu_done) begin
                        top_reg   <= alu_result;
                        count_reg <= cnt_m1;
                        state_reg <= done_state;
                    end
                end
                S_TAIL: begin
                    if (tail_fire) begin
                        m_value_reg  <= tail_value;
                        m_status_reg <= tail_status;
                        count_reg    <= '0;
                        pending_reg  <= '0;
                        dp_reg       <= 1'b0;
                        err_reg      <= pfe_pkg::ST_OK;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pfe_pkg::COUNT_W'(pfe_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_alu_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == S_ALU))
        else $error("ALU finished outside the operate step");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != pfe_pkg::ST_OK) && !tail_fire |=> $stable(err_reg))
        else $error("error code changed before the end of the expression");

    a_value_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pfe_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("nonzero value reported with an error status");

endmodule

`default_nettype wire
